@@ rtl/bcl_pkg.sv @@
`timescale 1ns / 1ps

package bcl_pkg;

	localparam logic [1:0] CMD_GET     = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_PIN     = 2'd2;
	localparam logic [1:0] CMD_UNPIN   = 2'd3;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NO_FREE   = 2'd1;
	localparam logic [1:0] STS_UNDERFLOW = 2'd2;
	localparam logic [1:0] STS_OVERFLOW  = 2'd3;

	localparam logic [7:0] COUNT_MAX = 8'hff;

	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
		logic        vld;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/bcl_ram.sv @@
`timescale 1ns / 1ps

module bcl_ram #(
	parameter int WIDTH = 81,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/block_buffer_cache_lru_unit.sv @@
`timescale 1ns / 1ps

// buffer cache tag table with reference counts and oldest-release replacement
// input channel: in_valid / in_stall carries one command item (get, release,
// pin, unpin); output channel: out_valid / out_stall carries one result item
// per command. in_stall is high while a command is being worked on.
// a get walks every entry through the single read port of the entry ram, one
// entry per cycle, with one tag compare and one stamp compare shared across
// the walk; after the last entry it passes through the drain and final states.
// release, pin and unpin read one entry and then take the same drain and final states.
// one command is in flight at a time; the next item can be taken in the cycle
// after the result is committed, so a new command never overlaps the last one.
// the result sits in an output register; the next item is accepted while it
// waits. if the receiver stalls and a new result is ready, the block holds in
// its final state until the output register frees up, and only then commits
// the entry update.
// reset (arst_n low, asynchronous) clears control state and a per-entry
// written bit; an entry never written reads as all zero, so no clearing pass
// is needed and the block takes items right after reset.

module block_buffer_cache_lru_unit #(
	parameter int ENTRY_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  device_id,
	input  logic [31:0] block_number,
	input  logic [4:0]  entry_index,
	input  logic [31:0] now_tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  result_index,
	output logic        data_valid,
	output logic [1:0]  status,
	output logic [7:0]  ref_count
);

	localparam int IW = $clog2(ENTRY_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRY_COUNT - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;

	// entry_index wraps modulo the table size
	logic [IW-1:0] mod_tbl [32];
	for (genvar g = 0; g < 32; g++) begin : g_mod
		assign mod_tbl[g] = IW'(g % ENTRY_COUNT);
	end

	logic [1:0]    cmd_q;
	logic [7:0]    dev_q;
	logic [31:0]   blk_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   now_q;
	logic [IW-1:0] ptr_q;

	logic [ENTRY_COUNT-1:0] init_q;

	logic                      chk_s1;
	logic [IW-1:0]             chk_idx_s1;
	logic                      init_s1;
	logic [bcl_pkg::ENTRY_W-1:0] ram_rdata;
	bcl_pkg::entry_t           rd_word;

	logic            hit_q;
	logic [IW-1:0]   hit_idx_q;
	bcl_pkg::entry_t hit_word_q;
	logic            found_q;
	logic [IW-1:0]   pick_idx_q;
	logic [31:0]     best_q;

	logic [IW-1:0]   rd_addr;
	logic            accept;
	logic            commit;
	logic            tag_match;
	logic            is_free;

	logic            do_wr;
	logic [IW-1:0]   wr_idx;
	bcl_pkg::entry_t wr_word;
	logic [IW-1:0]   r_idx;
	logic            r_valid;
	logic [1:0]      r_status;
	logic [7:0]      r_count;

	logic        out_valid_q;
	logic [4:0]  result_index_q;
	logic        data_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  ref_count_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign commit   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign rd_addr  = (state_q == ST_RD) ? idx_q : ptr_q;

	bcl_ram #(
		.WIDTH(bcl_pkg::ENTRY_W),
		.DEPTH(ENTRY_COUNT)
	) u_entries (
		.clk  (clk),
		.we   (do_wr),
		.waddr(wr_idx),
		.wdata(wr_word),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// never-written entries read as the reset value
	assign rd_word   = init_s1 ? bcl_pkg::entry_t'(ram_rdata) : '0;
	assign tag_match = (rd_word.dev == dev_q) && (rd_word.blk == blk_q);
	assign is_free   = (rd_word.cnt == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chk_s1  <= 1'b0;
			hit_q   <= 1'b0;
			found_q <= 1'b0;
			init_q  <= '0;
		end else begin
			chk_s1 <= (state_q == ST_SCAN) || (state_q == ST_RD);
			if (do_wr) begin
				init_q[wr_idx] <= 1'b1;
			end
			if (accept) begin
				hit_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (chk_s1) begin
				// first match wins; single-entry commands just capture the entry
				if ((cmd_q != bcl_pkg::CMD_GET) || (tag_match && !hit_q)) begin
					hit_q <= 1'b1;
				end
				if (is_free && (!found_q || rd_word.stamp < best_q)) begin
					found_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (cmd == bcl_pkg::CMD_GET) ? ST_SCAN : ST_RD;
					end
				end
				ST_SCAN: begin
					if (ptr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_RD: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_addr;
		init_s1    <= init_q[rd_addr];
		if (accept) begin
			cmd_q <= cmd;
			dev_q <= device_id;
			blk_q <= block_number;
			idx_q <= mod_tbl[entry_index];
			now_q <= now_tick;
			ptr_q <= '0;
		end else if (state_q == ST_SCAN) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (chk_s1) begin
			if ((cmd_q != bcl_pkg::CMD_GET) || (tag_match && !hit_q)) begin
				hit_idx_q  <= chk_idx_s1;
				hit_word_q <= rd_word;
			end
			if (is_free && (!found_q || rd_word.stamp < best_q)) begin
				pick_idx_q <= chk_idx_s1;
				best_q     <= rd_word.stamp;
			end
		end
	end

	// final update and result of the command
	always_comb begin
		wr_idx   = hit_idx_q;
		wr_word  = hit_word_q;
		r_idx    = hit_idx_q;
		r_valid  = hit_word_q.vld;
		r_status = bcl_pkg::STS_OK;
		r_count  = hit_word_q.cnt;
		do_wr    = 1'b0;
		case (cmd_q)
			bcl_pkg::CMD_GET: begin
				if (hit_q) begin
					if (hit_word_q.cnt == bcl_pkg::COUNT_MAX) begin
						r_status = bcl_pkg::STS_OVERFLOW;
					end else begin
						wr_word.cnt = hit_word_q.cnt + 8'd1;
						wr_word.vld = 1'b1;
						r_count     = wr_word.cnt;
						do_wr       = commit;
					end
				end else if (found_q) begin
					wr_idx        = pick_idx_q;
					wr_word.dev   = dev_q;
					wr_word.blk   = blk_q;
					wr_word.cnt   = 8'd1;
					wr_word.vld   = 1'b1;
					wr_word.stamp = best_q;
					r_idx         = pick_idx_q;
					r_valid       = 1'b0;
					r_count       = 8'd1;
					do_wr         = commit;
				end else begin
					r_idx    = '0;
					r_valid  = 1'b0;
					r_status = bcl_pkg::STS_NO_FREE;
					r_count  = 8'd0;
				end
			end
			bcl_pkg::CMD_PIN: begin
				if (hit_word_q.cnt == bcl_pkg::COUNT_MAX) begin
					r_status = bcl_pkg::STS_OVERFLOW;
				end else begin
					wr_word.cnt = hit_word_q.cnt + 8'd1;
					r_count     = wr_word.cnt;
					do_wr       = commit;
				end
			end
			bcl_pkg::CMD_RELEASE, bcl_pkg::CMD_UNPIN: begin
				if (hit_word_q.cnt == 8'd0) begin
					r_status = bcl_pkg::STS_UNDERFLOW;
				end else begin
					wr_word.cnt = hit_word_q.cnt - 8'd1;
					// final release stamps the entry for replacement order
					if ((cmd_q == bcl_pkg::CMD_RELEASE) && (wr_word.cnt == 8'd0)) begin
						wr_word.stamp = now_q;
					end
					r_count = wr_word.cnt;
					do_wr   = commit;
				end
			end
			default: begin
				do_wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_index_q <= 5'(r_idx);
			data_valid_q   <= r_valid;
			status_q       <= r_status;
			ref_count_q    <= r_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_index = result_index_q;
	assign data_valid   = data_valid_q;
	assign status       = status_q;
	assign ref_count    = ref_count_q;

	a_rose_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the final state");

	a_write_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr |-> (state_q == ST_DONE) && (!out_valid_q || !out_stall))
		else $error("entry written before the result slot was free");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second item taken while a command is in flight");

	a_no_free_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == bcl_pkg::STS_NO_FREE) |->
			(ref_count_q == 8'd0) && (result_index_q == 5'd0) && !data_valid_q)
		else $error("no-free result carries nonzero fields");

endmodule
